>>> hdl/fh_ecpri_pkg.sv
// ----------------------------------------------------------------------------
// fh_ecpri_pkg
// Shared types and constants of the fronthaul eCPRI packet classifier.
// ----------------------------------------------------------------------------
package fh_ecpri_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PRACH_EAXC_LIST  = 3'd0;
    localparam logic [2:0] REG_PRACH_EAXC_COUNT = 3'd1;
    localparam logic [2:0] REG_SRS_CLASSIFY_EN  = 3'd2;
    localparam logic [2:0] REG_FORCE_SRS_EN     = 3'd3;
    localparam logic [2:0] REG_FORCE_SRS_SF     = 3'd4;
    localparam logic [2:0] REG_FORCE_SRS_SLOT   = 3'd5;
    localparam logic [2:0] REG_FORCE_SRS_SYM    = 3'd6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // frame class codes
    localparam logic [1:0] CLASS_PRACH    = 2'd0;
    localparam logic [1:0] CLASS_SRS      = 2'd1;
    localparam logic [1:0] CLASS_OTHER    = 2'd2;
    localparam logic [1:0] CLASS_UNPARSED = 2'd3;

    // ethernet tag protocol ids that push the ecpri header back
    localparam logic [15:0] TPID_VLAN = 16'h8100;
    localparam logic [15:0] TPID_QINQ = 16'h88a8;

    // frame byte positions
    localparam int ETYPE_LO_POS   = 13;
    localparam int OFF_PLAIN      = 14;
    localparam int OFF_TAGGED     = 18;
    localparam int MIN_PARSE_LEN  = 22;
    localparam int MIN_TIMING_LEN = 30;
    localparam int ECPRI_HDR_LEN  = 6;
    localparam int OFH_HDR_LEN    = 16;

    // positions relative to the ecpri header start
    localparam int REL_MSG_TYPE = 1;
    localparam int REL_PCID_LO  = 5;
    localparam int REL_SFN      = 9;
    localparam int REL_SYM      = 11;
    localparam int REL_PRB_LO   = 14;
    localparam int REL_NPRB     = 15;

    localparam int M_TDATA_W = 72;

    // result payload, last member in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  prb_count;
        logic [9:0]  start_prb;
        logic [5:0]  symbol_id;
        logic [5:0]  slot_id;
        logic [3:0]  subframe_id;
        logic [7:0]  frame_number;
        logic        timing_valid;
        logic [7:0]  message_type;
        logic [15:0] carrier_id;
        logic [1:0]  prach_index;
    } result_data_t;

    typedef struct packed {
        logic [1:0]   frame_class;
        result_data_t data;
    } result_t;

endpackage

>>> hdl/fh_ecpri_ram.sv
// ----------------------------------------------------------------------------
// fh_ecpri_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fh_ecpri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/fronthaul_ecpri_packet_classifier_unit.sv
// ----------------------------------------------------------------------------
// fronthaul_ecpri_packet_classifier_unit
// Classifies O-RAN fronthaul eCPRI frames as PRACH, SRS, other or unparsed.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on the s_ stream, tlast on the
// final byte, and gives one result per frame on the m_ stream: tuser holds
// the frame class, tdata the eCPRI and O-RAN header fields. Bytes are written
// into a header RAM; stage 2 pairs each byte with its predecessor from the
// RAM's registered read port. m_tvalid follows the last byte through stage
// 2 and the result buffer. Input runs at one byte per cycle while the result
// side keeps up; s_tready drops while the second result entry is full, or
// while the first entry is full, a result is in flight and m_tready is low.
// There is no clearing pass after reset. Bytes past PEEK_BYTES are ignored.
// ----------------------------------------------------------------------------
module fronthaul_ecpri_packet_classifier_unit
    import fh_ecpri_pkg::*;
#(
    parameter int PEEK_BYTES     = 48,
    parameter int MAX_PRACH_EAXC = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // frame byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // frame_byte
    input  logic                  s_tlast,   // end_of_frame
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // prach_index[1:0], carrier_id[17:2], message_type[25:18],
    // timing_valid[26], frame_number[34:27], subframe_id[38:35],
    // slot_id[44:39], symbol_id[50:45], start_prb[60:51], prb_count[68:61],
    // zero pad[71:69]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [1:0]            m_tuser    // frame_class
);

    localparam int AW = (PEEK_BYTES > 1) ? $clog2(PEEK_BYTES) : 1;
    localparam int CW = $clog2(PEEK_BYTES + 1);
    localparam logic [CW-1:0] PEEK_CNT = CW'(PEEK_BYTES);
    localparam logic [2:0]    MAX_CNT  = 3'(MAX_PRACH_EAXC);

    // configuration registers
    logic [63:0] eaxc_list_reg;
    logic [2:0]  eaxc_count_reg;
    logic        srs_en_reg;
    logic        force_en_reg;
    logic [3:0]  force_sf_reg;
    logic [5:0]  force_slot_reg;
    logic [5:0]  force_sym_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eaxc_list_reg  <= '0;
            eaxc_count_reg <= '0;
            srs_en_reg     <= 1'b0;
            force_en_reg   <= 1'b0;
            force_sf_reg   <= '0;
            force_slot_reg <= '0;
            force_sym_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PRACH_EAXC_LIST:  eaxc_list_reg  <= cfg_wdata;
                REG_PRACH_EAXC_COUNT: eaxc_count_reg <= cfg_wdata[2:0];
                REG_SRS_CLASSIFY_EN:  srs_en_reg     <= cfg_wdata[0];
                REG_FORCE_SRS_EN:     force_en_reg   <= cfg_wdata[0];
                REG_FORCE_SRS_SF:     force_sf_reg   <= cfg_wdata[3:0];
                REG_FORCE_SRS_SLOT:   force_slot_reg <= cfg_wdata[5:0];
                REG_FORCE_SRS_SYM:    force_sym_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: byte counter, header ram write and predecessor read
    // ------------------------------------------------------------------
    logic          s_xfer;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] cnt_inc;
    logic          kept;
    logic [CW-1:0] prev_addr;
    logic [7:0]    prev_byte;

    assign s_xfer  = s_tvalid && s_tready;
    assign kept    = (cnt_reg < PEEK_CNT);
    assign cnt_inc = kept ? (cnt_reg + CW'(1)) : cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_xfer) begin
            cnt_next = s_tlast ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign prev_addr = (cnt_reg == '0) ? '0 : (cnt_reg - CW'(1));

    fh_ecpri_ram #(
        .WIDTH (8),
        .DEPTH (PEEK_BYTES)
    ) u_header_store (
        .aclk    (aclk),
        .wr_en   (s_xfer && kept),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (s_xfer),
        .rd_addr (prev_addr[AW-1:0]),
        .rd_data (prev_byte)
    );

    // stage 2 registers
    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic          s2_kept_reg;
    logic [CW-1:0] s2_pos_reg;
    logic [CW-1:0] s2_len_reg;
    logic [7:0]    s2_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s_xfer;
            s2_last_reg  <= s_xfer && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s2_kept_reg <= kept;
            s2_pos_reg  <= cnt_reg;
            s2_len_reg  <= cnt_inc;
            s2_byte_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: field capture from current and previous byte
    // ------------------------------------------------------------------
    logic          tagged_reg, tagged_next;
    logic [7:0]    msg_reg, msg_next;
    logic [15:0]   pcid_reg, pcid_next;
    logic [7:0]    sfn_reg, sfn_next;
    logic [3:0]    sf_reg, sf_next;
    logic [5:0]    slot_reg, slot_next;
    logic [5:0]    sym_reg, sym_next;
    logic [9:0]    sprb_reg, sprb_next;
    logic [7:0]    nprb_reg, nprb_next;
    logic [CW-1:0] hdr_off;
    logic [CW-1:0] rel;
    logic          in_hdr;

    assign hdr_off = tagged_reg ? CW'(OFF_TAGGED) : CW'(OFF_PLAIN);
    assign in_hdr  = s2_valid_reg && s2_kept_reg && (s2_pos_reg >= hdr_off);
    assign rel     = s2_pos_reg - hdr_off;

    always_comb begin
        tagged_next = tagged_reg;
        msg_next    = msg_reg;
        pcid_next   = pcid_reg;
        sfn_next    = sfn_reg;
        sf_next     = sf_reg;
        slot_next   = slot_reg;
        sym_next    = sym_reg;
        sprb_next   = sprb_reg;
        nprb_next   = nprb_reg;
        // ethertype decides the header offset
        if (s2_valid_reg && s2_kept_reg && (s2_pos_reg == CW'(ETYPE_LO_POS))) begin
            tagged_next = ({prev_byte, s2_byte_reg} == TPID_VLAN) ||
                          ({prev_byte, s2_byte_reg} == TPID_QINQ);
        end
        if (in_hdr) begin
            if (rel == CW'(REL_MSG_TYPE)) begin
                msg_next = s2_byte_reg;
            end
            if (rel == CW'(REL_PCID_LO)) begin
                pcid_next = {prev_byte, s2_byte_reg};
            end
            if (rel == CW'(REL_SFN)) begin
                sfn_next = s2_byte_reg;
            end
            if (rel == CW'(REL_SYM)) begin
                sf_next   = prev_byte[7:4];
                slot_next = {prev_byte[3:0], s2_byte_reg[7:6]};
                sym_next  = s2_byte_reg[5:0];
            end
            if (rel == CW'(REL_PRB_LO)) begin
                sprb_next = {prev_byte[1:0], s2_byte_reg};
            end
            if (rel == CW'(REL_NPRB)) begin
                nprb_next = s2_byte_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tagged_reg <= 1'b0;
        end else begin
            tagged_reg <= tagged_next;
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg  <= msg_next;
        pcid_reg <= pcid_next;
        sfn_reg  <= sfn_next;
        sf_reg   <= sf_next;
        slot_reg <= slot_next;
        sym_reg  <= sym_next;
        sprb_reg <= sprb_next;
        nprb_reg <= nprb_next;
    end

    // ------------------------------------------------------------------
    // classification on the final byte
    // ------------------------------------------------------------------
    logic       parsed;
    logic       timing_ok;
    logic [2:0] n_eff;
    logic       prach_hit;
    logic [1:0] prach_idx;
    logic       srs_hit;
    result_t    res_new;

    assign parsed    = (s2_len_reg >= CW'(MIN_PARSE_LEN)) &&
                       ((hdr_off + CW'(ECPRI_HDR_LEN)) <= s2_len_reg);
    assign timing_ok = (s2_len_reg >= CW'(MIN_TIMING_LEN)) &&
                       ((hdr_off + CW'(OFH_HDR_LEN)) <= s2_len_reg);
    assign n_eff     = (eaxc_count_reg > MAX_CNT) ? MAX_CNT : eaxc_count_reg;

    // first matching eaxc entry wins
    always_comb begin
        prach_hit = 1'b0;
        prach_idx = '0;
        for (int k = MAX_PRACH_EAXC - 1; k >= 0; k--) begin
            if ((msg_next == 8'd0) && (3'(k) < n_eff) &&
                (eaxc_list_reg[16*k +: 16] == pcid_next)) begin
                prach_hit = 1'b1;
                prach_idx = 2'(k);
            end
        end
    end

    assign srs_hit = srs_en_reg && force_en_reg && (msg_next == 8'd0) && timing_ok &&
                     (sf_next == force_sf_reg) && (slot_next == force_slot_reg) &&
                     (sym_next == force_sym_reg);

    always_comb begin
        res_new = '0;
        if (!parsed) begin
            res_new.frame_class = CLASS_UNPARSED;
        end else begin
            priority if (prach_hit) begin
                res_new.frame_class = CLASS_PRACH;
            end else if (srs_hit) begin
                res_new.frame_class = CLASS_SRS;
            end else begin
                res_new.frame_class = CLASS_OTHER;
            end
            res_new.data.prach_index  = prach_hit ? prach_idx : 2'd0;
            res_new.data.carrier_id   = pcid_next;
            res_new.data.message_type = msg_next;
            if (timing_ok) begin
                res_new.data.timing_valid = 1'b1;
                res_new.data.frame_number = sfn_next;
                res_new.data.subframe_id  = sf_next;
                res_new.data.slot_id      = slot_next;
                res_new.data.symbol_id    = sym_next;
                res_new.data.start_prb    = sprb_next;
                res_new.data.prb_count    = nprb_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // two-entry result buffer
    // ------------------------------------------------------------------
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    push, pop;

    assign push     = s2_last_reg;
    assign pop      = out_valid_reg && m_tready;
    assign s_tready = !(skid_valid_reg || (out_valid_reg && s2_last_reg && !m_tready));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg  <= skid_reg;
                skid_reg <= res_new;
            end else begin
                out_reg  <= res_new;
            end
        end else if (push) begin
            skid_reg <= res_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.frame_class;

endmodule

>>> hdl/fh_ecpri_checker.sv
// ----------------------------------------------------------------------------
// fh_ecpri_checker
// Port-level checks on the result stream of the classifier, bound to the top.
// ----------------------------------------------------------------------------
module fh_ecpri_checker
    import fh_ecpri_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result transfer offered right after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // unparsed frames carry an all-zero payload
    a_unparsed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == CLASS_UNPARSED)) |-> (m_tdata == '0))
        else $error("unparsed result with nonzero fields");

    // srs class needs timing, and missing timing zeroes the timing fields
    a_srs_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == CLASS_SRS)) |-> m_tdata[26])
        else $error("srs class without timing fields");

    a_no_timing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[26]) |-> (m_tdata[71:27] == '0))
        else $error("timing fields set without timing_valid");

endmodule

bind fronthaul_ecpri_packet_classifier_unit fh_ecpri_checker u_fh_ecpri_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/ecpri_classifier_checker.sv
// ----------------------------------------------------------------------------
// ecpri_classifier_checker
// Watches the configuration port and both streams of the eCPRI classifier.
// It keeps its own copy of the registers and of the kept header bytes, works
// out the result of every frame at its final byte and compares each result
// transfer, field by field, with the oldest frame still waiting.
// ----------------------------------------------------------------------------
module ecpri_classifier_checker
    import fh_ecpri_pkg::*;
#(
    parameter int PEEK_BYTES     = 48,
    parameter int MAX_PRACH_EAXC = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [1:0]            m_tuser,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);

    // register copies
    logic [63:0] eaxc_list;
    logic [2:0]  eaxc_count;
    logic        srs_enable;
    logic        force_enable;
    logic [3:0]  force_sf;
    logic [5:0]  force_slot;
    logic [5:0]  force_sym;

    // header bytes of the frame in progress
    logic [7:0]   hdr_bytes [0:PEEK_BYTES-1];
    int           kept_bytes;

    result_t      expected_q [$];
    result_t      want;
    result_data_t got;
    int           mismatches;
    int           compared;

    // classify the kept bytes of a finished frame of kept length len
    function automatic result_t classify_frame(input int len);
        result_t     r;
        int          off;
        int          n;
        int          k;
        logic        hit;
        logic [1:0]  hit_idx;
        logic [15:0] etype;
        logic [7:0]  bss;
        logic [7:0]  bst;
        r = '0;
        hit = 1'b0;
        hit_idx = 2'd0;
        if (len < MIN_PARSE_LEN) begin
            r.frame_class = CLASS_UNPARSED;
            return r;
        end
        etype = {hdr_bytes[12], hdr_bytes[13]};
        off = (etype == TPID_VLAN || etype == TPID_QINQ) ? OFF_TAGGED : OFF_PLAIN;
        if (off + ECPRI_HDR_LEN > len) begin
            r.frame_class = CLASS_UNPARSED;
            return r;
        end
        // ecpri common header: msg type at +1, pc_id at +4..+5
        r.data.message_type = hdr_bytes[off + 1];
        r.data.carrier_id   = {hdr_bytes[off + 4], hdr_bytes[off + 5]};

        // first matching prach id among the valid entries
        n = (eaxc_count > MAX_PRACH_EAXC) ? MAX_PRACH_EAXC : int'(eaxc_count);
        if (r.data.message_type == 8'h00) begin
            for (k = 0; k < n; k++) begin
                if (!hit && eaxc_list[16*k +: 16] == r.data.carrier_id) begin
                    hit = 1'b1;
                    hit_idx = k[1:0];
                end
            end
        end

        // o-ran timing and section fields
        if (len >= MIN_TIMING_LEN && off + OFH_HDR_LEN <= len) begin
            bss = hdr_bytes[off + 10];
            bst = hdr_bytes[off + 11];
            r.data.timing_valid = 1'b1;
            r.data.frame_number = hdr_bytes[off + 9];
            r.data.subframe_id  = bss[7:4];
            r.data.slot_id      = {bss[3:0], bst[7:6]};
            r.data.symbol_id    = bst[5:0];
            r.data.start_prb    = {hdr_bytes[off + 13][1:0], hdr_bytes[off + 14]};
            r.data.prb_count    = hdr_bytes[off + 15];
        end

        if (hit) begin
            r.frame_class = CLASS_PRACH;
            r.data.prach_index = hit_idx;
        end else if (srs_enable && force_enable && r.data.message_type == 8'h00 &&
                     r.data.timing_valid && r.data.subframe_id == force_sf &&
                     r.data.slot_id == force_slot && r.data.symbol_id == force_sym) begin
            r.frame_class = CLASS_SRS;
        end else begin
            r.frame_class = CLASS_OTHER;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            eaxc_list    = '0;
            eaxc_count   = '0;
            srs_enable   = 1'b0;
            force_enable = 1'b0;
            force_sf     = '0;
            force_slot   = '0;
            force_sym    = '0;
            kept_bytes   = 0;
            expected_q.delete();
        end else begin
            // register writes, masked to register width
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PRACH_EAXC_LIST:  eaxc_list    = cfg_wdata;
                    REG_PRACH_EAXC_COUNT: eaxc_count   = cfg_wdata[2:0];
                    REG_SRS_CLASSIFY_EN:  srs_enable   = cfg_wdata[0];
                    REG_FORCE_SRS_EN:     force_enable = cfg_wdata[0];
                    REG_FORCE_SRS_SF:     force_sf     = cfg_wdata[3:0];
                    REG_FORCE_SRS_SLOT:   force_slot   = cfg_wdata[5:0];
                    REG_FORCE_SRS_SYM:    force_sym    = cfg_wdata[5:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest waiting frame
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no frame waiting (class %0d)", m_tuser);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    got  = result_data_t'(m_tdata);
                    compared++;
                    check_field("frame_class",  16'(want.frame_class),
                                16'(m_tuser));
                    check_field("prach_index",  16'(want.data.prach_index),
                                16'(got.prach_index));
                    check_field("carrier_id",   want.data.carrier_id,
                                got.carrier_id);
                    check_field("message_type", 16'(want.data.message_type),
                                16'(got.message_type));
                    check_field("timing_valid", 16'(want.data.timing_valid),
                                16'(got.timing_valid));
                    check_field("frame_number", 16'(want.data.frame_number),
                                16'(got.frame_number));
                    check_field("subframe_id",  16'(want.data.subframe_id),
                                16'(got.subframe_id));
                    check_field("slot_id",      16'(want.data.slot_id),
                                16'(got.slot_id));
                    check_field("symbol_id",    16'(want.data.symbol_id),
                                16'(got.symbol_id));
                    check_field("start_prb",    16'(want.data.start_prb),
                                16'(got.start_prb));
                    check_field("prb_count",    16'(want.data.prb_count),
                                16'(got.prb_count));
                    check_field("pad",          16'(want.data.pad),
                                16'(got.pad));
                end
            end

            // byte transfer: keep the head of the frame, classify at the last byte
            if (s_tvalid && s_tready) begin
                if (kept_bytes < PEEK_BYTES) begin
                    hdr_bytes[kept_bytes] = s_tdata;
                    kept_bytes++;
                end
                if (s_tlast) begin
                    expected_q.insert(expected_q.size(), classify_frame(kept_bytes));
                    kept_bytes = 0;
                end
            end
        end
        fail_count   <= mismatches;
        pending      <= expected_q.size();
        results_seen <= compared;
    end

endmodule

>>> dv/fronthaul_ecpri_packet_classifier_unit_test.sv
// ----------------------------------------------------------------------------
// fronthaul_ecpri_packet_classifier_unit_test
// Drives frame bytes into the eCPRI classifier with random gaps and result
// stalls. Directed frames hit the length limits, tagged headers, every class
// and duplicate ids; random phases under changing register settings send
// mostly well-formed frames, plus cut-off frames and noise.
// ----------------------------------------------------------------------------
module fronthaul_ecpri_packet_classifier_unit_test;
    import fh_ecpri_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_PHASES = 5;
    localparam int          PHASE_BYTES   = 280;
    localparam logic [15:0] ECPRI_ETYPE   = 16'hAEFE;
    localparam logic [2:0]  REG_SPARE     = 3'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int frames_sent = 0;
    int cfg_writes  = 0;
    bit tx_steady   = 1'b0;

    // current settings, used only to steer the stimulus
    logic [63:0] eaxc_ids;
    logic [3:0]  sf_set;
    logic [5:0]  slot_set;
    logic [5:0]  sym_set;

    logic [7:0]  frame_bytes [$];

    fronthaul_ecpri_packet_classifier_unit #(
        .PEEK_BYTES     (48),
        .MAX_PRACH_EAXC (4)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ecpri_classifier_checker #(
        .PEEK_BYTES     (48),
        .MAX_PRACH_EAXC (4)
    ) frame_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall before each transfer, with steady stretches
    initial begin : result_sink
        int stall;
        bit rx_steady;
        rx_steady = 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one byte transfer after a random gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // append one byte to the frame under construction
    function automatic void add_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    task automatic push_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frames_sent++;
    endtask

    // ethernet + ecpri + o-ran header, padded or cut to len bytes
    task automatic send_ecpri_frame(input logic [15:0] etype, input logic [7:0] msg,
                                    input logic [15:0] pcid, input logic [3:0] sf,
                                    input logic [5:0] slot, input logic [5:0] sym,
                                    input int len);
        int i;
        frame_bytes.delete();
        for (i = 0; i < 12; i++) add_byte(8'($urandom_range(0, 255)));
        add_byte(etype[15:8]);
        add_byte(etype[7:0]);
        if (etype == TPID_VLAN || etype == TPID_QINQ) begin
            add_byte(8'($urandom_range(0, 255)));
            add_byte(8'($urandom_range(0, 255)));
            add_byte(ECPRI_ETYPE[15:8]);
            add_byte(ECPRI_ETYPE[7:0]);
        end
        // ecpri: revision, msg type, payload size, pc_id, seq id
        add_byte(8'h10);
        add_byte(msg);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        add_byte(pcid[15:8]);
        add_byte(pcid[7:0]);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        // o-ran: flags, frame id, subframe/slot, slot/symbol, section and prbs
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        add_byte({sf, slot[5:2]});
        add_byte({slot[1:0], sym});
        for (i = 0; i < 4; i++) add_byte(8'($urandom_range(0, 255)));
        while (frame_bytes.size() < len) add_byte(8'($urandom_range(0, 255)));
        while (frame_bytes.size() > len) frame_bytes.delete(frame_bytes.size() - 1);
        push_frame();
    endtask

    task automatic send_noise_frame(input int len);
        frame_bytes.delete();
        repeat (len) add_byte(8'($urandom_range(0, 255)));
        push_frame();
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_writes++;
    endtask

    task automatic apply_settings(input logic [63:0] list_v, input logic [63:0] count_v,
                                  input logic [63:0] srs_v, input logic [63:0] force_v,
                                  input logic [63:0] sf_v, input logic [63:0] slot_v,
                                  input logic [63:0] sym_v);
        write_reg(REG_PRACH_EAXC_LIST, list_v);
        write_reg(REG_PRACH_EAXC_COUNT, count_v);
        write_reg(REG_SRS_CLASSIFY_EN, srs_v);
        write_reg(REG_FORCE_SRS_EN, force_v);
        write_reg(REG_FORCE_SRS_SF, sf_v);
        write_reg(REG_FORCE_SRS_SLOT, slot_v);
        write_reg(REG_FORCE_SRS_SYM, sym_v);
        cfg_we   <= 1'b0;
        eaxc_ids = list_v;
        sf_set   = sf_v[3:0];
        slot_set = slot_v[5:0];
        sym_set  = sym_v[5:0];
    endtask

    // hold off input until every result is back, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          phase;
        int          phase_start;
        int          kind;
        int          off;
        int          len;
        logic [15:0] etype;
        logic [7:0]  msg;
        logic [15:0] pcid;
        logic [3:0]  sf;
        logic [5:0]  slot;
        logic [5:0]  sym;
        logic [63:0] list_v;
        logic [63:0] srs_v;
        logic [63:0] force_v;

        eaxc_ids = '0;
        sf_set   = '0;
        slot_set = '0;
        sym_set  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // settings after reset: no prach ids, srs off; length limits
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h0000, 4'd0, 6'd0, 6'd0, 1);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h0000, 4'd0, 6'd0, 6'd0, 21);
        send_ecpri_frame(ECPRI_ETYPE, 8'hFF, 16'hFFFF, 4'd15, 6'd63, 6'd63, 22);
        send_ecpri_frame(TPID_VLAN, 8'h00, 16'h1234, 4'd0, 6'd0, 6'd0, 22);
        send_ecpri_frame(TPID_QINQ, 8'h00, 16'h8001, 4'd0, 6'd0, 6'd0, 24);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h00FF, 4'd9, 6'd33, 6'd12, 29);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h0000, 4'd15, 6'd63, 6'd63, 30);
        send_ecpri_frame(TPID_VLAN, 8'h00, 16'hFF00, 4'd5, 6'd2, 6'd1, 33);
        send_ecpri_frame(TPID_VLAN, 8'h00, 16'hFF00, 4'd5, 6'd2, 6'd1, 34);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h0000, 4'd0, 6'd0, 6'd0, 64);
        wait_drained();

        // all-ones settings: count above the entry limit, duplicate last ids
        write_reg(REG_SPARE, '1);
        apply_settings({16'hFFFF, 16'hFFFF, 16'h0000, 16'hA5C3}, '1, '1, '1, '1, '1, '1);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'hA5C3, 4'd1, 6'd2, 6'd3, 30);
        send_ecpri_frame(TPID_VLAN, 8'h00, 16'h0000, 4'd1, 6'd2, 6'd3, 40);
        send_ecpri_frame(TPID_QINQ, 8'h00, 16'hFFFF, 4'd1, 6'd2, 6'd3, 34);
        send_ecpri_frame(ECPRI_ETYPE, 8'h01, 16'hA5C3, 4'd15, 6'd63, 6'd63, 30);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h1111, 4'd15, 6'd63, 6'd63, 30);
        send_ecpri_frame(ECPRI_ETYPE, 8'h80, 16'h1111, 4'd15, 6'd63, 6'd63, 30);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h1111, 4'd14, 6'd63, 6'd63, 30);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h1111, 4'd15, 6'd63, 6'd62, 30);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'hA5C3, 4'd15, 6'd63, 6'd63, 30);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'h1111, 4'd15, 6'd63, 6'd63, 29);
        send_ecpri_frame(ECPRI_ETYPE, 8'h00, 16'hA5C3, 4'd0, 6'd0, 6'd0, 22);
        wait_drained();

        // random phases: all zeros first, then random settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                apply_settings('0, '0, '0, '0, '0, '0, '0);
            end else begin
                list_v = {$urandom, $urandom};
                if ($urandom_range(0, 3) == 0) list_v[63:48] = list_v[15:0];
                srs_v = {$urandom, $urandom};
                srs_v[0] = ($urandom_range(0, 3) != 0);
                force_v = {$urandom, $urandom};
                force_v[0] = ($urandom_range(0, 3) != 0);
                apply_settings(list_v, {$urandom, $urandom}, srs_v, force_v,
                               {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom});
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 4) == 0) tx_steady = !tx_steady;
                kind = $urandom_range(0, 99);
                if (kind < 85) begin
                    case ($urandom_range(0, 3))
                        0, 1:    etype = ECPRI_ETYPE;
                        2:       etype = TPID_VLAN;
                        default: etype = TPID_QINQ;
                    endcase
                    off  = (etype == ECPRI_ETYPE) ? OFF_PLAIN : OFF_TAGGED;
                    msg  = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
                    pcid = ($urandom_range(0, 1) == 1) ?
                           eaxc_ids[16*$urandom_range(0, 3) +: 16] : 16'($urandom);
                    if ($urandom_range(0, 4) < 2) begin
                        sf = sf_set;
                        slot = slot_set;
                        sym = sym_set;
                    end else begin
                        sf = 4'($urandom);
                        slot = 6'($urandom);
                        sym = 6'($urandom);
                    end
                    // well-formed most of the time, else cut off inside the header
                    if (kind < 70) begin
                        len = off + OFH_HDR_LEN +
                              (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                           : $urandom_range(0, 30));
                    end else begin
                        len = $urandom_range(1, off + OFH_HDR_LEN);
                    end
                    send_ecpri_frame(etype, msg, pcid, sf, slot, sym, len);
                end else begin
                    send_noise_frame($urandom_range(1, 64));
                end
                if ($urandom_range(0, 29) == 0) wait_drained();
            end
            wait_drained();
        end

        // final drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run covered %0d bytes in %0d frames, %0d results compared",
                 bytes_sent, frames_sent, results_seen);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, RANDOM_PHASES + 2, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
